### rtl/pidd_pkg.sv
// ----------------------------------------------------------------------------
// pidd_pkg
// Shared types and constants for the deadband PID drive controller.
// ----------------------------------------------------------------------------
package pidd_pkg;

  localparam int DRIVE_LIMIT = 255;
  localparam int INTEG_LIMIT = 200;

  localparam longint ONE_Q16   = 65536;
  localparam longint PROP_MAX  = 67108863;
  localparam longint INTEG_MAX = 33554431;
  localparam longint ILIM_RAW  = longint'(INTEG_LIMIT) * ONE_Q16;
  localparam longint ILIM_Q16  = (ILIM_RAW > INTEG_MAX) ? INTEG_MAX : ILIM_RAW;
  localparam longint DLIM_Q16  = longint'(DRIVE_LIMIT) * ONE_Q16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KI        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd4;

  localparam logic [15:0] KP_RESET     = 16'd410;
  localparam logic [15:0] KI_RESET     = 16'd1024;
  localparam logic [15:0] KD_RESET     = 16'd66;
  localparam logic [15:0] SETTLE_RESET = 16'd1000;
  localparam logic [31:0] MS_PER_S     = 32'd1000;

  typedef struct packed {
    logic signed [15:0] error;
    logic [31:0]        now_ms;
  } pidd_in_t;

  typedef struct packed {
    logic signed [8:0] drive;
    logic              integ_cleared;
  } pidd_out_t;

  // command to the bit-serial multiply / divide unit
  typedef struct packed {
    logic        is_div;
    logic [6:0]  steps;
    logic [31:0] a;
    logic [63:0] b;
  } pidd_cmd_t;

endpackage

### rtl/pidd_serial.sv
// ----------------------------------------------------------------------------
// pidd_serial
// Bit-serial unsigned unit: shift-add multiply (a * b[31:0], 32 steps) or
// restoring divide (left-aligned dividend b by divisor a, one bit per step).
// ----------------------------------------------------------------------------
module pidd_serial (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pidd_pkg::pidd_cmd_t cmd,
  output logic                busy,
  output logic                done,
  output logic [63:0]         result
);

  logic        is_div;
  logic [6:0]  cnt;
  logic [63:0] acc;
  logic [31:0] opnd;
  logic [31:0] rem;

  logic [32:0] msum;
  logic [32:0] trial;
  logic        ge;
  logic [32:0] tdiff;

  always_comb begin
    msum  = {1'b0, acc[63:32]} + (acc[0] ? {1'b0, opnd} : 33'd0);
    trial = {rem, acc[63]};
    ge    = trial >= {1'b0, opnd};
    tdiff = trial - {1'b0, opnd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == 7'd1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
        is_div <= cmd.is_div;
        acc  <= cmd.b;
        opnd <= cmd.a;
        rem  <= 32'd0;
      end else if (busy) begin
        if (is_div) begin
          rem <= ge ? tdiff[31:0] : trial[31:0];
          acc <= {acc[62:0], ge};
        end else begin
          acc <= {msum, acc[31:1]};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign result = acc;

endmodule

### rtl/pid_deadband_integrator_reset.sv
// ----------------------------------------------------------------------------
// pid_deadband_integrator_reset
// PID motor drive with deadband, clamped integrator and settle reset.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one beat of {error, now_ms}; each beat yields one
//   out beat of {drive, integ_cleared} on out_valid/out_stall.
//   cfg_valid/cfg_ready write a register by index (threshold, kp_gain,
//   ki_gain, kd_gain, settle_ms); write only while idle. cfg_ready is
//   always high.
//   Timing: error at or below threshold goes from accept through the settle
//   and drive steps to out_valid. Above threshold the terms go through one
//   bit-serial multiply/divide unit: 4 multiplies of 32 steps, a 64-step
//   divide by 1000 and a 32-step divide by dt, each handed on to the next.
//   One item is in flight at a time; no new beat is accepted until the
//   drive step has passed its result to the output register.
//   The result sits in an output register, so a new beat is accepted while
//   the previous result is stalled; the block only waits at its last step
//   if that register is still full.
//   rst (synchronous) restores register defaults and clears all terms.
// ----------------------------------------------------------------------------
module pid_deadband_integrator_reset (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pidd_pkg::pidd_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pidd_pkg::pidd_out_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pidd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_PMUL, S_IMUL1, S_IMUL2, S_IDIV, S_DMUL, S_DDIV, S_SETTLE, S_DRIVE
  } state_t;

  localparam logic signed [28:0] ILIM = 29'(pidd_pkg::ILIM_Q16);
  localparam logic signed [33:0] DLIM = 34'(pidd_pkg::DLIM_Q16);
  localparam logic signed [26:0] PMAX = 27'(pidd_pkg::PROP_MAX);
  localparam logic signed [25:0] ONE26 = 26'(pidd_pkg::ONE_Q16);

  state_t state;

  logic signed [15:0] threshold;
  logic [15:0] kp_gain, ki_gain, kd_gain, settle_ms;

  logic signed [26:0] prop_term;
  logic signed [25:0] integ_term;
  logic signed [31:0] deriv_term;
  logic signed [15:0] prev_error;
  logic [31:0] prev_time, settle_start, now_q, dt;
  logic settle_armed, upd, err_neg, diff_neg, cleared;
  logic [15:0] err_mag;
  logic [16:0] diff_mag;

  logic u_start, u_busy, u_done;
  pidd_pkg::pidd_cmd_t u_cmd;
  logic [63:0] u_res;

  pidd_serial u_serial (
    .clk(clk), .rst(rst), .start(u_start), .cmd(u_cmd),
    .busy(u_busy), .done(u_done), .result(u_res)
  );

  // accept-side values
  logic signed [16:0] err_x, diff_x;
  always_comb begin
    err_x  = {in_data.error[15], in_data.error};
    diff_x = err_x - {prev_error[15], prev_error};
  end

  // proportional saturation
  logic signed [26:0] prop_next;
  always_comb begin
    if (!err_neg) prop_next = (u_res[31:0] > 32'(PMAX)) ? PMAX : 27'(u_res[31:0]);
    else prop_next = (u_res[31:0] > 32'(PMAX) + 32'd1) ? (-PMAX - 27'sd1)
                                                      : -27'(u_res[31:0]);
  end

  // integrator add and clamp
  logic signed [28:0] isum;
  logic signed [25:0] integ_next;
  always_comb begin
    isum = {{3{integ_term[25]}}, integ_term}
         + (err_neg ? -{2'b00, u_res[26:0]} : {2'b00, u_res[26:0]});
    if (|u_res[63:27]) integ_next = err_neg ? -26'(ILIM) : 26'(ILIM);
    else if (isum > ILIM) integ_next = 26'(ILIM);
    else if (isum < -ILIM) integ_next = -26'(ILIM);
    else integ_next = isum[25:0];
  end

  // derivative saturation
  logic signed [31:0] deriv_next;
  always_comb begin
    if (!diff_neg) deriv_next = u_res[31] ? 32'h7fff_ffff : u_res[31:0];
    else deriv_next = (u_res[31:0] > 32'h8000_0000) ? 32'h8000_0000 : -u_res[31:0];
  end

  // drive sum, clamp, truncate toward zero
  logic signed [33:0] dsum, dclamp;
  logic signed [17:0] dshift;
  logic signed [8:0]  drive_next;
  always_comb begin
    dsum = {{7{prop_term[26]}}, prop_term} + {{8{integ_term[25]}}, integ_term}
         + {{2{deriv_term[31]}}, deriv_term};
    if (dsum > DLIM) dclamp = DLIM;
    else if (dsum < -DLIM) dclamp = -DLIM;
    else dclamp = dsum;
    dshift = dclamp[33:16];
    if (dclamp[33] && (dclamp[15:0] != 16'd0)) dshift = dshift + 18'sd1;
    drive_next = dshift[8:0];
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      threshold    <= 16'sd0;
      kp_gain      <= pidd_pkg::KP_RESET;
      ki_gain      <= pidd_pkg::KI_RESET;
      kd_gain      <= pidd_pkg::KD_RESET;
      settle_ms    <= pidd_pkg::SETTLE_RESET;
      prop_term    <= '0;
      integ_term   <= '0;
      deriv_term   <= '0;
      prev_error   <= '0;
      prev_time    <= '0;
      settle_start <= '0;
      settle_armed <= 1'b0;
      out_valid    <= 1'b0;
      u_start      <= 1'b0;
    end else begin
      // every step but the last hands its result on to a new unit run
      u_start <= ((state == S_IDLE) && in_valid && (in_data.error > threshold)) ||
                 (u_done && (state != S_DDIV));
      if (out_valid && !out_stall && (state != S_DRIVE)) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pidd_pkg::CFG_THRESHOLD: threshold <= cfg_data;
          pidd_pkg::CFG_KP:        kp_gain   <= cfg_data;
          pidd_pkg::CFG_KI:        ki_gain   <= cfg_data;
          pidd_pkg::CFG_KD:        kd_gain   <= cfg_data;
          pidd_pkg::CFG_SETTLE:    settle_ms <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            err_neg    <= in_data.error[15];
            err_mag    <= in_data.error[15] ? 16'(-err_x) : 16'(err_x);
            diff_neg   <= diff_x[16];
            diff_mag   <= diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
            dt         <= in_data.now_ms - prev_time;
            now_q      <= in_data.now_ms;
            upd        <= in_data.error > threshold;
            cleared    <= 1'b0;
            prev_error <= in_data.error;
            prev_time  <= in_data.now_ms;
            if (in_data.error > threshold) begin
              u_cmd   <= '{is_div: 1'b0, steps: 7'd32, a: {16'd0, kp_gain},
                           b: {48'd0, (in_data.error[15] ? 16'(-err_x) : 16'(err_x))}};
              state   <= S_PMUL;
            end else begin
              state <= S_SETTLE;
            end
          end
        end
        S_PMUL: begin
          if (u_done) begin
            prop_term <= prop_next;
            u_cmd   <= '{is_div: 1'b0, steps: 7'd32, a: {16'd0, ki_gain},
                         b: {48'd0, err_mag}};
            state   <= S_IMUL1;
          end
        end
        S_IMUL1: begin
          if (u_done) begin
            u_cmd   <= '{is_div: 1'b0, steps: 7'd32, a: u_res[31:0], b: {32'd0, dt}};
            state   <= S_IMUL2;
          end
        end
        S_IMUL2: begin
          if (u_done) begin
            u_cmd   <= '{is_div: 1'b1, steps: 7'd64, a: pidd_pkg::MS_PER_S, b: u_res};
            state   <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (u_done) begin
            integ_term <= integ_next;
            u_cmd   <= '{is_div: 1'b0, steps: 7'd32, a: {16'd0, kd_gain},
                         b: {47'd0, diff_mag}};
            state   <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (u_done) begin
            u_cmd   <= '{is_div: 1'b1, steps: 7'd32,
                         a: (dt == 32'd0) ? 32'd1 : dt, b: {u_res[31:0], 32'd0}};
            state   <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (u_done) begin
            deriv_term <= deriv_next;
            state      <= S_SETTLE;
          end
        end
        S_SETTLE: begin
          if (!upd && (integ_term >= ONE26 || integ_term <= -ONE26)) begin
            if (!settle_armed) begin
              settle_start <= now_q;
              settle_armed <= 1'b1;
            end else if ((now_q - settle_start) >= {16'd0, settle_ms}) begin
              settle_start <= '0;
              settle_armed <= 1'b0;
              integ_term   <= '0;
              cleared      <= 1'b1;
            end
          end
          state <= S_DRIVE;
        end
        S_DRIVE: begin
          if (!out_valid || !out_stall) begin
            out_valid              <= 1'b1;
            out_data.drive         <= drive_next;
            out_data.integ_cleared <= cleared;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a new result only ever comes from the drive step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DRIVE))
    else $error("out_valid rose outside drive step");

  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    ($signed({{3{integ_term[25]}}, integ_term}) <= ILIM) &&
    ($signed({{3{integ_term[25]}}, integ_term}) >= -ILIM))
    else $error("integrator outside clamp");

  a_done_state: assert property (@(posedge clk) disable iff (rst)
    u_done |-> (state == S_PMUL || state == S_IMUL1 || state == S_IMUL2 ||
                state == S_IDIV || state == S_DMUL || state == S_DDIV))
    else $error("serial unit finished with no consumer");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    u_start |-> !u_busy)
    else $error("serial unit restarted while busy");

endmodule
